FILE: src/vspv_pkg.sv
// Package for the visual servo PID velocity block: formats, register codes,
// sequencer states, the 1.05 power table and rounding helpers.
// No dependencies.
package vspv_pkg;

  localparam int PIXEL_FRAC_BITS = 4;
  localparam int VEL_FRAC_BITS   = 12;
  localparam int WORK_FRAC       = VEL_FRAC_BITS + 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ERR_W   = 18;
  localparam int DV_W    = 37;
  localparam int DEN_W   = 22;
  localparam int MA_W    = 48;
  localparam int MB_W    = 18;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int FAC_W   = 17;
  localparam int VEL_W   = 14;
  localparam int YAW_W   = 13;

  localparam int ANG_PI      = 12868;
  localparam int ANG_HALF_PI = 6434;
  localparam int INTEG_LIM   = 500 << WORK_FRAC;
  localparam int NEAR_LIM    = 50 << (PIXEL_FRAC_BITS + 1);
  localparam int YAW_LIM     = 80 << (PIXEL_FRAC_BITS + 1);
  localparam int TALL_LIM    = 100 << PIXEL_FRAC_BITS;
  localparam int VEL_ONE     = 1 << VEL_FRAC_BITS;
  localparam int VZ_DOWN     = -((4 * VEL_ONE + 2) / 5);
  localparam int VZ_UP       = (VEL_ONE + 5) / 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_PROP_GAIN, REG_INTEG_GAIN,
    REG_DERIV_GAIN, REG_YAW_GAIN, REG_TARGET_ALT
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_E_GO, S_E_WAIT, S_P_MUL, S_P_RES, S_I_GO, S_I_WAIT, S_I_MUL,
    S_I_RES, S_D_MUL, S_D_RES, S_F_MUL, S_F_P, S_F_I, S_F_D, S_AXIS_END,
    S_Z_GO, S_Z_WAIT, S_Y_CHK, S_Y_MUL, S_Y_RES, S_Y_GO, S_Y_WAIT, S_FINISH
  } st_t;

  typedef logic [30:0] pow_tab_t [0:50];

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t tab;
    logic [63:0] t;
    t = 64'd1 << 30;
    tab[50] = 31'(t);
    for (int j = 49; j >= 0; j--) begin
      t = (t * 64'd20 + 64'd10) / 64'd21;
      tab[j] = 31'(t);
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

  function automatic logic [FAC_W-1:0] near_factor(input logic [ERR_W-2:0] a);
    logic [5:0]  k;
    logic [4:0]  f;
    logic [30:0] lo;
    logic [30:0] hi;
    logic [36:0] step;
    logic [31:0] q30;
    k = (a < (ERR_W-1)'(NEAR_LIM)) ? a[10:5] : 6'd49;
    f = a[4:0];
    lo = POW_TAB[k];
    hi = POW_TAB[k + 6'd1];
    step = (37'(hi - lo) * 37'(f) + 37'd16) >> 5;
    q30 = 32'(lo) + 32'(step);
    return FAC_W'((q30 + 32'd8192) >> 14);
  endfunction

  function automatic logic signed [PROD_W-1:0] rnd_shr(
      input logic signed [PROD_W-1:0] v, input int s);
    logic [PROD_W-1:0] m;
    m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    m = (m + (PROD_W'(1) << (s - 1))) >> s;
    return v[PROD_W-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [PROD_W-1:0] sat(
      input logic signed [PROD_W-1:0] v, input logic signed [PROD_W-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

endpackage

FILE: src/vspv_if.sv
// Item channels of the visual servo block: box input and velocity command.
// Depends on vspv_pkg.
interface vspv_box_if;
  logic valid;
  logic ready;
  logic box_present;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic [13:0] box_angle;
  logic signed [15:0] altitude;
  modport source(output valid, box_present, center_x, center_y, box_width,
                 box_height, box_angle, altitude, input ready);
  modport sink(input valid, box_present, center_x, center_y, box_width,
               box_height, box_angle, altitude, output ready);
endinterface

interface vspv_cmd_if;
  logic valid;
  logic ready;
  logic hold;
  logic signed [vspv_pkg::VEL_W-1:0] vel_x;
  logic signed [vspv_pkg::VEL_W-1:0] vel_y;
  logic signed [vspv_pkg::VEL_W-1:0] vel_z;
  logic signed [vspv_pkg::YAW_W-1:0] turn_rate;
  modport source(output valid, hold, vel_x, vel_y, vel_z, turn_rate, input ready);
  modport sink(input valid, hold, vel_x, vel_y, vel_z, turn_rate, output ready);
endinterface

FILE: src/visual_servo_pid_velocity.sv
// Top level of the visual servo PID velocity controller.
// Depends on vspv_pkg and the channel interfaces in vspv_if.sv.
//
// One box item gives one command item. Each item that is not a hold item uses
// a 37-iteration restoring divider, which runs two to six times per item
// (the normalized error of each axis, the integral step when the box is
// tall, the altitude band and the yaw smoothing), and a shared 48 by 18 bit
// multiplier. The block takes the next item while the last command still
// waits in the output register.
module visual_servo_pid_velocity (
  input  logic clk,
  input  logic rst,
  vspv_box_if.sink   box,
  vspv_cmd_if.source cmd,
  input  logic cfg_we,
  input  logic [vspv_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [vspv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vspv_pkg::*;

  st_t st, st_next;

  logic [11:0] image_width, image_height;
  logic [15:0] prop_gain, integ_gain, deriv_gain, yaw_gain;
  logic signed [15:0] target_altitude;

  logic signed [31:0] integral_x, integral_y, last_error_x, last_error_y;
  logic signed [15:0] last_turn_rate;

  logic axis;
  logic signed [ERR_W-1:0] ex, ey;
  logic [15:0] hgt, bw;
  logic [13:0] ang;
  logic signed [15:0] alt;
  logic hold;
  logic near;
  logic [FAC_W-1:0] fac;
  logic signed [31:0] e;
  logic signed [MA_W-1:0] p, i, d;
  logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
  logic signed [YAW_W-1:0] yaw, rate;

  logic signed [PROD_W-1:0] prod;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  logic [DEN_W-1:0] dv_rem, dv_den;
  logic [DV_W-1:0]  dv_quo;
  logic [5:0]       dv_cnt;
  logic             dv_neg;
  logic             dv_start;
  logic [DV_W-1:0]  dv_num_in;
  logic [DEN_W-1:0] dv_den_in;
  logic             dv_neg_in;
  logic [DEN_W:0]   dv_shift, dv_sub;
  logic             dv_ge;
  logic signed [DV_W:0] dv_q;

  logic signed [ERR_W-1:0] err_cur;
  logic [ERR_W-2:0] err_mag, ex_mag, ey_mag;
  logic signed [31:0] integ_cur, last_cur;
  logic [31:0] e_mag;
  logic [DEN_W-1:0] den_e;
  logic signed [32:0] diff;
  logic signed [37:0] diff20;
  logic signed [32:0] integ_sum;
  logic signed [PROD_W-1:0] vel_sum;
  logic signed [17:0] alt18, tgt18, z_diff;
  logic signed [21:0] z_num;
  logic signed [15:0] yraw, yerr;
  logic yaw_cond;
  logic signed [17:0] ysum;
  logic box_hold;

  always_comb begin
    err_cur  = axis ? ey : ex;
    err_mag  = err_cur[ERR_W-1] ? (ERR_W-1)'(-err_cur) : (ERR_W-1)'(err_cur);
    ex_mag   = ex[ERR_W-1] ? (ERR_W-1)'(-ex) : (ERR_W-1)'(ex);
    ey_mag   = ey[ERR_W-1] ? (ERR_W-1)'(-ey) : (ERR_W-1)'(ey);
    integ_cur = axis ? integral_y : integral_x;
    last_cur  = axis ? last_error_y : last_error_x;
    e_mag    = e[31] ? 32'(-e) : 32'(e);
    den_e    = (DEN_W'(hgt) << 5) + (DEN_W'(hgt) << 3);
    diff     = 33'(e) - 33'(last_cur);
    diff20   = (38'(diff) <<< 4) + (38'(diff) <<< 2);
    integ_sum = 33'(integ_cur) + 33'(dv_q);
    vel_sum  = PROD_W'(p) + PROD_W'(i) + PROD_W'(d);
    alt18    = 18'(alt);
    tgt18    = 18'(target_altitude);
    z_diff   = tgt18 - alt18;
    z_num    = 22'(z_diff) <<< 4;
    yraw     = ((bw >= hgt) ? 16'sd0 : 16'(ANG_HALF_PI)) - $signed({2'b00, ang});
    if (yraw > 16'(ANG_HALF_PI)) begin
      yerr = yraw - 16'(ANG_PI);
    end else if (yraw < -16'(ANG_HALF_PI)) begin
      yerr = yraw + 16'(ANG_PI);
    end else begin
      yerr = yraw;
    end
    yaw_cond = (ex_mag < (ERR_W-1)'(YAW_LIM)) && (ey_mag < (ERR_W-1)'(YAW_LIM))
               && (alt <= 16'sd1024);
    ysum     = 18'(rate) + (18'(last_turn_rate) <<< 3) + 18'(last_turn_rate);
    box_hold = !box.box_present || (box.box_height == 16'd0);
    dv_shift = {dv_rem, dv_quo[DV_W-1]};
    dv_ge    = dv_shift >= {1'b0, dv_den};
    dv_sub   = dv_shift - {1'b0, dv_den};
    dv_q     = dv_neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next   = st;
    box.ready = 1'b0;
    dv_start  = 1'b0;
    dv_num_in = '0;
    dv_den_in = '0;
    dv_neg_in = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (st)
      S_IDLE: begin
        box.ready = !rst;
        if (box.valid) begin
          st_next = box_hold ? S_FINISH : S_E_GO;
        end
      end
      S_E_GO: begin
        dv_start  = 1'b1;
        dv_num_in = DV_W'({err_mag, 16'd0}) + DV_W'({err_mag, 17'd0})
                    + DV_W'(den_e >> 1);
        dv_den_in = den_e;
        dv_neg_in = err_cur[ERR_W-1];
        st_next   = S_E_WAIT;
      end
      S_E_WAIT: if (dv_cnt == 6'd0) st_next = S_P_MUL;
      S_P_MUL: begin
        mul_a   = MA_W'(e);
        mul_b   = $signed({2'b00, prop_gain});
        st_next = S_P_RES;
      end
      S_P_RES: st_next = (hgt > 16'(TALL_LIM)) ? S_I_GO : S_I_MUL;
      S_I_GO: begin
        dv_start  = 1'b1;
        dv_num_in = DV_W'(e_mag) + DV_W'(10);
        dv_den_in = DEN_W'(20);
        dv_neg_in = e[31];
        st_next   = S_I_WAIT;
      end
      S_I_WAIT: if (dv_cnt == 6'd0) st_next = S_I_MUL;
      S_I_MUL: begin
        mul_a   = MA_W'(integ_cur);
        mul_b   = $signed({2'b00, integ_gain});
        st_next = S_I_RES;
      end
      S_I_RES: st_next = S_D_MUL;
      S_D_MUL: begin
        mul_a   = MA_W'(diff20);
        mul_b   = $signed({2'b00, deriv_gain});
        st_next = S_D_RES;
      end
      S_D_RES: st_next = near ? S_F_MUL : S_AXIS_END;
      S_F_MUL: begin
        mul_a   = p;
        mul_b   = $signed({1'b0, fac});
        st_next = S_F_P;
      end
      S_F_P: begin
        mul_a   = i;
        mul_b   = $signed({1'b0, fac});
        st_next = S_F_I;
      end
      S_F_I: begin
        mul_a   = d;
        mul_b   = $signed({1'b0, fac});
        st_next = S_F_D;
      end
      S_F_D: st_next = S_AXIS_END;
      S_AXIS_END: st_next = axis ? S_Z_GO : S_E_GO;
      S_Z_GO: begin
        if (alt18 > tgt18 + 18'sd1024 || alt18 < tgt18 - 18'sd51) begin
          st_next = S_Y_CHK;
        end else begin
          dv_start  = 1'b1;
          dv_num_in = DV_W'(z_num[21] ? -z_num : z_num) + DV_W'(10);
          dv_den_in = DEN_W'(20);
          dv_neg_in = z_num[21];
          st_next   = S_Z_WAIT;
        end
      end
      S_Z_WAIT: if (dv_cnt == 6'd0) st_next = S_Y_CHK;
      S_Y_CHK: begin
        if (!yaw_cond) begin
          st_next = S_FINISH;
        end else if ((yerr[15] ? -yerr : yerr) > 16'sd204) begin
          st_next = S_Y_MUL;
        end else begin
          st_next = S_Y_GO;
        end
      end
      S_Y_MUL: begin
        mul_a   = MA_W'(yerr);
        mul_b   = $signed({2'b00, yaw_gain});
        st_next = S_Y_RES;
      end
      S_Y_RES: st_next = S_Y_GO;
      S_Y_GO: begin
        dv_start  = 1'b1;
        dv_num_in = DV_W'(ysum[17] ? -ysum : ysum) + DV_W'(5);
        dv_den_in = DEN_W'(10);
        dv_neg_in = ysum[17];
        st_next   = S_Y_WAIT;
      end
      S_Y_WAIT: if (dv_cnt == 6'd0) st_next = S_FINISH;
      S_FINISH: if (!cmd.valid || cmd.ready) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (dv_start) begin
      dv_cnt <= 6'(DV_W);
    end else if (dv_cnt != 6'd0) begin
      dv_cnt <= dv_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_rem <= '0;
      dv_quo <= dv_num_in;
      dv_den <= dv_den_in;
      dv_neg <= dv_neg_in;
    end else if (dv_cnt != 6'd0) begin
      dv_rem <= dv_ge ? dv_sub[DEN_W-1:0] : dv_shift[DEN_W-1:0];
      dv_quo <= {dv_quo[DV_W-2:0], dv_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 12'd640;
      image_height    <= 12'd480;
      prop_gain       <= '0;
      integ_gain      <= '0;
      deriv_gain      <= '0;
      yaw_gain        <= '0;
      target_altitude <= 16'sd51;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width     <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: image_height    <= cfg_data[11:0];
        REG_PROP_GAIN:    prop_gain       <= cfg_data;
        REG_INTEG_GAIN:   integ_gain      <= cfg_data;
        REG_DERIV_GAIN:   deriv_gain      <= cfg_data;
        REG_YAW_GAIN:     yaw_gain        <= cfg_data;
        REG_TARGET_ALT:   target_altitude <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_x     <= '0;
      integral_y     <= '0;
      last_error_x   <= '0;
      last_error_y   <= '0;
      last_turn_rate <= '0;
      axis           <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          axis  <= 1'b0;
          ex    <= $signed({1'b0, box.center_x, 1'b0})
                   - $signed(ERR_W'({image_width, 4'd0}));
          ey    <= $signed({1'b0, box.center_y, 1'b0})
                   - $signed(ERR_W'({image_height, 4'd0}));
          hgt   <= box.box_height;
          bw    <= box.box_width;
          ang   <= box.box_angle;
          alt   <= box.altitude;
          hold  <= box_hold;
          vel_x <= '0;
          vel_y <= '0;
          vel_z <= '0;
          yaw   <= '0;
          rate  <= '0;
        end
        S_E_GO: begin
          fac  <= near_factor(err_mag);
          near <= err_mag < (ERR_W-1)'(NEAR_LIM);
        end
        S_E_WAIT: if (dv_cnt == 6'd0) e <= 32'(dv_q);
        S_P_RES: p <= MA_W'(rnd_shr(prod, 8));
        S_I_WAIT: begin
          if (dv_cnt == 6'd0) begin
            if (axis) begin
              integral_y <= 32'(sat(PROD_W'(integ_sum), PROD_W'(INTEG_LIM)));
            end else begin
              integral_x <= 32'(sat(PROD_W'(integ_sum), PROD_W'(INTEG_LIM)));
            end
          end
        end
        S_I_RES: i <= MA_W'(rnd_shr(prod, 8));
        S_D_RES: begin
          d <= MA_W'(rnd_shr(prod, 8));
          if (axis) last_error_y <= e;
          else last_error_x <= e;
        end
        S_F_P: p <= MA_W'(rnd_shr(prod, 16));
        S_F_I: i <= MA_W'(rnd_shr(prod, 16));
        S_F_D: begin
          d <= MA_W'(rnd_shr(prod, 16));
          if (axis) integral_y <= '0;
          else integral_x <= '0;
        end
        S_AXIS_END: begin
          axis <= 1'b1;
          if (axis) begin
            vel_x <= VEL_W'(sat(rnd_shr(-vel_sum, WORK_FRAC - VEL_FRAC_BITS),
                                PROD_W'(VEL_ONE)));
          end else begin
            vel_y <= VEL_W'(sat(rnd_shr(-vel_sum, WORK_FRAC - VEL_FRAC_BITS),
                                PROD_W'(VEL_ONE)));
          end
        end
        S_Z_GO: begin
          if (alt18 > tgt18 + 18'sd1024) vel_z <= VEL_W'(VZ_DOWN);
          else if (alt18 < tgt18 - 18'sd51) vel_z <= VEL_W'(VZ_UP);
        end
        S_Z_WAIT: if (dv_cnt == 6'd0) vel_z <= VEL_W'(dv_q);
        S_Y_CHK: if (!yaw_cond) last_turn_rate <= '0;
        S_Y_RES: rate <= YAW_W'(sat(rnd_shr(prod, 8), PROD_W'(2048)));
        S_Y_WAIT: begin
          if (dv_cnt == 6'd0) begin
            yaw            <= YAW_W'(dv_q);
            last_turn_rate <= 16'(dv_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (st == S_FINISH && (!cmd.valid || cmd.ready)) begin
      cmd.valid <= 1'b1;
    end else if (cmd.ready) begin
      cmd.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_FINISH && (!cmd.valid || cmd.ready)) begin
      cmd.hold      <= hold;
      cmd.vel_x     <= vel_x;
      cmd.vel_y     <= vel_y;
      cmd.vel_z     <= vel_z;
      cmd.turn_rate <= yaw;
    end
  end

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    dv_cnt != 6'd0 |-> (st == S_E_WAIT || st == S_I_WAIT || st == S_Z_WAIT ||
                        st == S_Y_WAIT))
    else $error("divider running outside a wait state");

  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    integral_x <= 32'sd32768000 && integral_x >= -32'sd32768000 &&
    integral_y <= 32'sd32768000 && integral_y >= -32'sd32768000)
    else $error("integral beyond its clamp");

  a_hold_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.hold |-> cmd.vel_x == '0 && cmd.vel_y == '0 &&
                              cmd.vel_z == '0 && cmd.turn_rate == '0)
    else $error("hold item with nonzero command");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    box.valid && box.ready |=> st != S_IDLE)
    else $error("accepted item did not start work");

endmodule
